>>> design/rppe_pkg.sv
// Shared constants and types for the remote plug pulse encoder.
package rppe_pkg;

    localparam int CODE_BITS   = 10;
    localparam int IN_CODE_W   = 10;
    localparam int CODE_EXT_W  = (CODE_BITS > IN_CODE_W) ? CODE_BITS : IN_CODE_W;
    localparam int FRAME_BITS  = CODE_BITS + 2;
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);
    localparam int SLOT_W      = 5;

    localparam logic [SLOT_W-1:0] SLOT_SHORT = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_LONG  = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_SYNC  = 5'd31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
    } frame_cmd_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

>>> design/rppe_front.sv
// Front end: accepts items, drops zero codes and builds the frame bit word.
module rppe_front
    import rppe_pkg::*;
(
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_CODE_W-1:0] socket_code,
    input  logic                 switch_on,
    input  q_stat_t              q_stat,
    output logic                 push,
    output frame_cmd_t           push_cmd
);

    logic [CODE_EXT_W-1:0] code_ext;

    assign code_ext = CODE_EXT_W'(socket_code);
    assign in_ready = ~q_stat.full;
    assign push     = in_valid & ~q_stat.full & (socket_code != '0);

    always_comb
    begin
        push_cmd.bits[FRAME_BITS-1:2] = code_ext[CODE_BITS-1:0];
        push_cmd.bits[1]              = switch_on;
        push_cmd.bits[0]              = ~switch_on;
    end

endmodule

>>> design/rppe_queue.sv
// Short command queue between front end and segment sequencer.
module rppe_queue
    import rppe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_cmd_t push_cmd,
    input  logic       pop,
    output frame_cmd_t pop_cmd,
    output q_stat_t    q_stat
);

    frame_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    assign q_stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign pop_cmd          = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = QCNT_W'(count_reg + 1'b1);
            2'b01:   count_next = QCNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/rppe_back.sv
// Back end: walks the frame word and emits one pulse segment per cycle unless out_ready holds it off.
module rppe_back
    import rppe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    input  frame_cmd_t        pop_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pin_level,
    output logic [SLOT_W-1:0] slot_count,
    output logic              frame_end
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BITS = 3'b010,
        ST_SYNC = 3'b100
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [FRAME_BITS-1:0] word_reg, word_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  lvl_reg, lvl_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  end_reg, end_next;
    logic                  emit, cur_bit, last_seg, load;

    assign emit     = (state_reg != ST_IDLE) & (~out_valid_reg | out_ready);
    assign cur_bit  = word_reg[bit_idx_reg];
    assign last_seg = (state_reg == ST_SYNC) & phase_reg[0];
    assign load     = q_stat.not_empty & ((state_reg == ST_IDLE) | (emit & last_seg));
    assign pop      = load;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        lvl_next       = lvl_reg;
        slot_next      = slot_reg;
        end_next       = end_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            end_next       = 1'b0;
            phase_next     = 2'(phase_reg + 1'b1);
            unique case (state_reg)
                ST_BITS:
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            lvl_next  = 1'b1;
                            slot_next = SLOT_SHORT;
                        end
                        2'd1:
                        begin
                            lvl_next  = 1'b0;
                            slot_next = SLOT_LONG;
                        end
                        2'd2:
                        begin
                            lvl_next  = 1'b1;
                            slot_next = cur_bit ? SLOT_SHORT : SLOT_LONG;
                        end
                        default:
                        begin
                            lvl_next  = 1'b0;
                            slot_next = cur_bit ? SLOT_LONG : SLOT_SHORT;
                            if (bit_idx_reg == '0)
                            begin
                                state_next = ST_SYNC;
                            end
                            else
                            begin
                                bit_idx_next = BIT_IDX_W'(bit_idx_reg - 1'b1);
                            end
                        end
                    endcase
                end
                default:
                begin
                    if (!phase_reg[0])
                    begin
                        lvl_next  = 1'b1;
                        slot_next = SLOT_SHORT;
                    end
                    else
                    begin
                        lvl_next   = 1'b0;
                        slot_next  = SLOT_SYNC;
                        end_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end

        if (load)
        begin
            state_next   = ST_BITS;
            phase_next   = '0;
            bit_idx_next = BIT_IDX_W'(FRAME_BITS - 1);
            word_next    = pop_cmd.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        lvl_reg  <= lvl_next;
        slot_reg <= slot_next;
        end_reg  <= end_next;
    end

    assign out_valid  = out_valid_reg;
    assign pin_level  = lvl_reg;
    assign slot_count = slot_reg;
    assign frame_end  = end_reg;

endmodule

>>> design/remote_plug_pulse_encoder_unit.sv
// Top level of the remote plug pulse encoder: front end, command queue and sequencer.
//
// Each accepted item with a non-zero plug code becomes one radio frame of
// 4*CODE_BITS+10 pulse segments (50 at ten code bits), one segment per output
// item: the code bits from the top down, the action pattern, then the sync
// pulse, whose long low segment carries frame_end. A zero code is accepted and
// produces nothing. The sequencer emits one segment per cycle while
// out_ready is high, so a steady stream of commands runs with no gap between
// frames. A two-entry command queue lets the input side take up to two
// further commands while a frame is still going out.
module remote_plug_pulse_encoder_unit
    import rppe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_CODE_W-1:0] socket_code,
    input  logic                 switch_on,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 pin_level,
    output logic [SLOT_W-1:0]    slot_count,
    output logic                 frame_end
);

    q_stat_t    q_stat;
    frame_cmd_t push_cmd;
    frame_cmd_t pop_cmd;
    logic       push;
    logic       pop;

    rppe_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .socket_code(socket_code),
        .switch_on  (switch_on),
        .q_stat     (q_stat),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    rppe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .q_stat  (q_stat)
    );

    rppe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pin_level (pin_level),
        .slot_count(slot_count),
        .frame_end (frame_end)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.not_empty)
        else $error("command popped from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> q_stat.not_empty)
        else $error("pushed command missing from queue");

    a_frame_end_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> !pin_level && slot_count == SLOT_SYNC)
        else $error("frame end on a segment other than the sync low");

    a_slot_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> slot_count == SLOT_SHORT || slot_count == SLOT_LONG
                      || slot_count == SLOT_SYNC)
        else $error("illegal segment duration");

endmodule
